>>> src/ffaa_pkg.sv
`timescale 1ns / 1ps

package ffaa_pkg;

   localparam int ARENA_BYTES  = 512;
   localparam int HEADER_BYTES = 7;
   localparam int AW           = $clog2(ARENA_BYTES);
   localparam int SENT_AT      = ARENA_BYTES - HEADER_BYTES;

   typedef logic [AW-1:0] off_type;
   typedef logic [AW:0]   offx_type;
   typedef logic [8:0]    ofs_type;

   localparam off_type HDR_A  = off_type'(HEADER_BYTES);
   localparam off_type SENT_A = off_type'(SENT_AT);

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_INIT  = 2'd2;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_OOM = 2'd1;
   localparam logic [1:0] ST_BAD = 2'd2;

   localparam logic [3:0] OP_NONE    = 4'd0;
   localparam logic [3:0] OP_SWEEP   = 4'd1;
   localparam logic [3:0] OP_A_FIRST = 4'd2;
   localparam logic [3:0] OP_A_WALK  = 4'd3;
   localparam logic [3:0] OP_A_TAKE  = 4'd4;
   localparam logic [3:0] OP_A_SPLIT = 4'd5;
   localparam logic [3:0] OP_A_FIX   = 4'd6;
   localparam logic [3:0] OP_F_FIRST = 4'd7;
   localparam logic [3:0] OP_F_HDR   = 4'd8;
   localparam logic [3:0] OP_F_NX    = 4'd9;
   localparam logic [3:0] OP_F_NN    = 4'd10;
   localparam logic [3:0] OP_F_WH    = 4'd11;
   localparam logic [3:0] OP_F_PV    = 4'd12;
   localparam logic [3:0] OP_F_PN    = 4'd13;
   localparam logic [3:0] OP_F_PI    = 4'd14;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [14:0] request_size;
      logic [8:0]  block_address;
   } req_type;

   typedef struct packed {
      ofs_type    payload_offset;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      logic    free;
      off_type prev;
      off_type next;
      off_type size;
   } hdr_type;

   typedef struct packed {
      logic       capture;
      logic [3:0] op;
      logic       done;
      logic [1:0] status;
      logic       give_off;
   } ctl_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       addr_bad;
      logic       fit;
      logic       split;
      logic       last;
      logic       hdr_valid;
      logic       nx_merge;
      logic       pv_free;
      logic       h_zero;
      logic       sweep_last;
   } sts_type;

endpackage

>>> src/first_fit_arena_allocator_top.sv
`timescale 1ns / 1ps

// First-fit allocator over a 512-byte arena with 7-byte in-band headers kept in a
// 512-entry header memory. A request is taken when start is high and busy is low;
// its single result appears on rsp_item for exactly one cycle with rsp_valid high
// and cannot be held off, so the receiver must take it then. After reset the block
// runs a clearing pass over the header memory, with busy high, before the first
// request. A reinitialize request repeats that pass and then answers. An allocate
// walks the chain, reading one header per block visited, and writes two more
// headers when the block is split. How long a free takes depends on whether the
// address is rejected and how many neighbors it merges with; an unused command
// answers with status OK.
module first_fit_arena_allocator_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ffaa_pkg::req_type req_item,
   output logic              rsp_valid,
   output ffaa_pkg::rsp_type rsp_item
);

   ffaa_pkg::ctl_type ctl;
   ffaa_pkg::sts_type sts;

   ffaa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctl       (ctl)
   );

   ffaa_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .ctl      (ctl),
      .sts      (sts),
      .rsp_item (rsp_item)
   );

endmodule

>>> src/ffaa_dp.sv
`timescale 1ns / 1ps

module ffaa_dp (
   input  logic              clock,
   input  logic              reset,
   input  ffaa_pkg::req_type req_item,
   input  ffaa_pkg::ctl_type ctl,
   output ffaa_pkg::sts_type sts,
   output ffaa_pkg::rsp_type rsp_item
);

   ffaa_pkg::hdr_type hdr_mem [ffaa_pkg::ARENA_BYTES];

   ffaa_pkg::req_type req_ff, req_in;
   ffaa_pkg::off_type cur_ff, cur_in;
   ffaa_pkg::off_type x_ff, x_in;
   ffaa_pkg::off_type cnt_ff, cnt_in;
   ffaa_pkg::hdr_type h_ff, h_in;
   ffaa_pkg::hdr_type rdata_ff;
   ffaa_pkg::rsp_type rsp_ff, rsp_in;

   logic              rd_en, wr_en;
   ffaa_pkg::off_type rd_addr, wr_addr;
   ffaa_pkg::hdr_type wr_data, init_hdr;
   ffaa_pkg::off_type req_lo, nw, hdr_addr;
   ffaa_pkg::offx_type addr_ext;

   assign req_lo   = req_ff.request_size[ffaa_pkg::AW-1:0];
   assign nw       = cur_ff + ffaa_pkg::HDR_A + req_lo;
   assign addr_ext = ffaa_pkg::offx_type'(req_ff.block_address);
   assign hdr_addr = ffaa_pkg::off_type'(addr_ext - ffaa_pkg::offx_type'(ffaa_pkg::HEADER_BYTES));

   // status back to the controller
   always_comb begin
      sts.cmd        = req_ff.cmd;
      sts.addr_bad   = (addr_ext < ffaa_pkg::offx_type'(ffaa_pkg::HEADER_BYTES))
                    || (addr_ext >= ffaa_pkg::offx_type'(ffaa_pkg::ARENA_BYTES));
      sts.fit        = rdata_ff.free
                    && (15'(rdata_ff.size) >= req_ff.request_size);
      sts.split      = (rdata_ff.size - req_lo) > ffaa_pkg::HDR_A;
      sts.last       = rdata_ff.next >= ffaa_pkg::SENT_A;
      sts.hdr_valid  = rdata_ff.valid;
      sts.nx_merge   = (x_ff < ffaa_pkg::SENT_A) && rdata_ff.free;
      sts.pv_free    = rdata_ff.free;
      sts.h_zero     = cur_ff == '0;
      sts.sweep_last = cnt_ff == ffaa_pkg::off_type'(ffaa_pkg::ARENA_BYTES - 1);
   end

   // arena image written by the clearing pass
   always_comb begin
      init_hdr = '0;
      if (cnt_ff == '0) begin
         init_hdr.valid = 1'b1;
         init_hdr.free  = 1'b1;
         init_hdr.next  = ffaa_pkg::SENT_A;
         init_hdr.size  = ffaa_pkg::off_type'(ffaa_pkg::ARENA_BYTES
                                              - 2 * ffaa_pkg::HEADER_BYTES);
      end else if (cnt_ff == ffaa_pkg::SENT_A) begin
         init_hdr.valid = 1'b1;
      end
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      req_in  = req_ff;
      cur_in  = cur_ff;
      x_in    = x_ff;
      cnt_in  = cnt_ff;
      h_in    = h_ff;
      rsp_in  = rsp_ff;
      case (ctl.op)
         ffaa_pkg::OP_SWEEP: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = init_hdr;
            cnt_in  = cnt_ff + 1'b1;
         end
         ffaa_pkg::OP_A_FIRST: begin
            rd_en   = 1'b1;
            rd_addr = '0;
            cur_in  = '0;
         end
         ffaa_pkg::OP_A_WALK: begin
            rd_en   = 1'b1;
            rd_addr = rdata_ff.next;
            cur_in  = rdata_ff.next;
         end
         ffaa_pkg::OP_A_TAKE: begin
            wr_en        = 1'b1;
            wr_addr      = cur_ff;
            wr_data      = rdata_ff;
            wr_data.free = 1'b0;
            if (sts.split) begin
               wr_data.next = nw;
               wr_data.size = req_lo;
            end
            h_in    = rdata_ff;
            rd_en   = 1'b1;
            rd_addr = rdata_ff.next;
         end
         ffaa_pkg::OP_A_SPLIT: begin
            wr_en         = 1'b1;
            wr_addr       = nw;
            wr_data.valid = 1'b1;
            wr_data.free  = 1'b1;
            wr_data.prev  = cur_ff;
            wr_data.next  = h_ff.next;
            wr_data.size  = h_ff.size - req_lo - ffaa_pkg::HDR_A;
         end
         ffaa_pkg::OP_A_FIX: begin
            wr_en        = 1'b1;
            wr_addr      = h_ff.next;
            wr_data      = rdata_ff;
            wr_data.prev = nw;
         end
         ffaa_pkg::OP_F_FIRST: begin
            rd_en   = 1'b1;
            rd_addr = hdr_addr;
            cur_in  = hdr_addr;
         end
         ffaa_pkg::OP_F_HDR: begin
            h_in      = rdata_ff;
            h_in.free = 1'b1;
            x_in      = rdata_ff.next;
            rd_en     = 1'b1;
            rd_addr   = rdata_ff.next;
         end
         ffaa_pkg::OP_F_NX: begin
            wr_en     = 1'b1;
            wr_addr   = x_ff;
            h_in.size = h_ff.size + rdata_ff.size + ffaa_pkg::HDR_A;
            h_in.next = rdata_ff.next;
            rd_en     = 1'b1;
            rd_addr   = rdata_ff.next;
         end
         ffaa_pkg::OP_F_NN: begin
            wr_en        = 1'b1;
            wr_addr      = h_ff.next;
            wr_data      = rdata_ff;
            wr_data.prev = cur_ff;
         end
         ffaa_pkg::OP_F_WH: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff;
            wr_data = h_ff;
            rd_en   = 1'b1;
            rd_addr = h_ff.prev;
            x_in    = h_ff.prev;
         end
         ffaa_pkg::OP_F_PV: begin
            wr_en        = 1'b1;
            wr_addr      = x_ff;
            wr_data      = rdata_ff;
            wr_data.size = rdata_ff.size + h_ff.size + ffaa_pkg::HDR_A;
            wr_data.next = h_ff.next;
            rd_en        = 1'b1;
            rd_addr      = h_ff.next;
         end
         ffaa_pkg::OP_F_PN: begin
            wr_en        = 1'b1;
            wr_addr      = h_ff.next;
            wr_data      = rdata_ff;
            wr_data.prev = x_ff;
         end
         ffaa_pkg::OP_F_PI: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff;
         end
         default: begin
         end
      endcase
      if (ctl.capture) begin
         req_in = req_item;
         cnt_in = '0;
      end
      if (ctl.done) begin
         rsp_in.status         = ctl.status;
         rsp_in.payload_offset = ctl.give_off
                               ? ffaa_pkg::ofs_type'(cur_ff + ffaa_pkg::HDR_A) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      cur_ff <= cur_in;
      x_ff   <= x_in;
      h_ff   <= h_in;
      rsp_ff <= rsp_in;
   end

   // header memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hdr_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= hdr_mem[rd_addr];
      end
   end

   assign rsp_item = rsp_ff;

endmodule

>>> src/ffaa_ctrl.sv
`timescale 1ns / 1ps

module ffaa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ffaa_pkg::sts_type sts,
   output logic              busy,
   output logic              rsp_valid,
   output ffaa_pkg::ctl_type ctl
);

   localparam logic [3:0] S_CLR     = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_GO      = 4'd2;
   localparam logic [3:0] S_A_CHK   = 4'd3;
   localparam logic [3:0] S_A_SPLIT = 4'd4;
   localparam logic [3:0] S_A_FIX   = 4'd5;
   localparam logic [3:0] S_F_HDR   = 4'd6;
   localparam logic [3:0] S_F_NX    = 4'd7;
   localparam logic [3:0] S_F_NN    = 4'd8;
   localparam logic [3:0] S_F_WH    = 4'd9;
   localparam logic [3:0] S_F_PV    = 4'd10;
   localparam logic [3:0] S_F_PN    = 4'd11;
   localparam logic [3:0] S_F_PI    = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       pend_ff, pend_in;
   logic       rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      ctl      = '0;
      case (state_ff)
         S_CLR: begin
            ctl.op = ffaa_pkg::OP_SWEEP;
            if (sts.sweep_last) begin
               state_in   = S_IDLE;
               ctl.done   = pend_ff;
               ctl.status = ffaa_pkg::ST_OK;
               pend_in    = 1'b0;
            end
         end
         S_IDLE: begin
            if (start) begin
               ctl.capture = 1'b1;
               state_in    = S_GO;
            end
         end
         S_GO: begin
            case (sts.cmd)
               ffaa_pkg::CMD_ALLOC: begin
                  ctl.op   = ffaa_pkg::OP_A_FIRST;
                  state_in = S_A_CHK;
               end
               ffaa_pkg::CMD_FREE: begin
                  if (sts.addr_bad) begin
                     ctl.done   = 1'b1;
                     ctl.status = ffaa_pkg::ST_BAD;
                     state_in   = S_IDLE;
                  end else begin
                     ctl.op   = ffaa_pkg::OP_F_FIRST;
                     state_in = S_F_HDR;
                  end
               end
               ffaa_pkg::CMD_INIT: begin
                  pend_in  = 1'b1;
                  state_in = S_CLR;
               end
               default: begin
                  ctl.done   = 1'b1;
                  ctl.status = ffaa_pkg::ST_OK;
                  state_in   = S_IDLE;
               end
            endcase
         end
         S_A_CHK: begin
            if (sts.fit) begin
               ctl.op = ffaa_pkg::OP_A_TAKE;
               if (sts.split) begin
                  state_in = S_A_SPLIT;
               end else begin
                  ctl.done     = 1'b1;
                  ctl.status   = ffaa_pkg::ST_OK;
                  ctl.give_off = 1'b1;
                  state_in     = S_IDLE;
               end
            end else if (sts.last) begin
               ctl.done   = 1'b1;
               ctl.status = ffaa_pkg::ST_OOM;
               state_in   = S_IDLE;
            end else begin
               ctl.op = ffaa_pkg::OP_A_WALK;
            end
         end
         S_A_SPLIT: begin
            ctl.op   = ffaa_pkg::OP_A_SPLIT;
            state_in = S_A_FIX;
         end
         S_A_FIX: begin
            ctl.op       = ffaa_pkg::OP_A_FIX;
            ctl.done     = 1'b1;
            ctl.status   = ffaa_pkg::ST_OK;
            ctl.give_off = 1'b1;
            state_in     = S_IDLE;
         end
         S_F_HDR: begin
            if (!sts.hdr_valid) begin
               ctl.done   = 1'b1;
               ctl.status = ffaa_pkg::ST_BAD;
               state_in   = S_IDLE;
            end else begin
               ctl.op   = ffaa_pkg::OP_F_HDR;
               state_in = S_F_NX;
            end
         end
         S_F_NX: begin
            if (sts.nx_merge) begin
               ctl.op   = ffaa_pkg::OP_F_NX;
               state_in = S_F_NN;
            end else begin
               state_in = S_F_WH;
            end
         end
         S_F_NN: begin
            ctl.op   = ffaa_pkg::OP_F_NN;
            state_in = S_F_WH;
         end
         S_F_WH: begin
            ctl.op = ffaa_pkg::OP_F_WH;
            if (sts.h_zero) begin
               ctl.done   = 1'b1;
               ctl.status = ffaa_pkg::ST_OK;
               state_in   = S_IDLE;
            end else begin
               state_in = S_F_PV;
            end
         end
         S_F_PV: begin
            if (sts.pv_free) begin
               ctl.op   = ffaa_pkg::OP_F_PV;
               state_in = S_F_PN;
            end else begin
               ctl.done   = 1'b1;
               ctl.status = ffaa_pkg::ST_OK;
               state_in   = S_IDLE;
            end
         end
         S_F_PN: begin
            ctl.op   = ffaa_pkg::OP_F_PN;
            state_in = S_F_PI;
         end
         S_F_PI: begin
            ctl.op     = ffaa_pkg::OP_F_PI;
            ctl.done   = 1'b1;
            ctl.status = ffaa_pkg::ST_OK;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= ctl.done;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> src/ffaa_checker.sv
`timescale 1ns / 1ps

module ffaa_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input ffaa_pkg::rsp_type rsp_item
);

   // a result is a single-cycle strobe
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // a taken request makes the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request");

   // a result closes out the request
   a_idle_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy still high while result shown");

   // failures carry no offset
   a_fail_zero_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status != ffaa_pkg::ST_OK)
      |-> rsp_item.payload_offset == '0)
      else $error("nonzero offset on failed request");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.status == ffaa_pkg::ST_OK
                  || rsp_item.status == ffaa_pkg::ST_OOM
                  || rsp_item.status == ffaa_pkg::ST_BAD))
      else $error("undefined status code");

endmodule

bind first_fit_arena_allocator_top ffaa_checker u_ffaa_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

>>> bench/tb_first_fit_arena_allocator_top.sv
`timescale 1ns / 1ps

module tb_first_fit_arena_allocator_top;
   import ffaa_pkg::*;

   localparam int         RANDOM_ITEMS = 1900;
   localparam int         CALM_TAIL    = 200;
   localparam int         STALL_LIMIT  = 3000;
   localparam int         DRAIN_CYCLES = 600;
   localparam logic [1:0] CMD_SPARE    = 2'd3;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } script_row;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;

   bit blk_live [ARENA_BYTES];
   bit blk_open [ARENA_BYTES];
   int blk_prev [ARENA_BYTES];
   int blk_next [ARENA_BYTES];
   int blk_size [ARENA_BYTES];

   rsp_type   grant_q [$];
   script_row script [$];
   int        bad_count    = 0;
   int        stall_cycles = 0;
   int        idle_pct     = 30;

   first_fit_arena_allocator_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always #5 clock = ~clock;

   function automatic void arena_format();
      for (int i = 0; i < ARENA_BYTES; i++) begin
         blk_live[i] = 1'b0;
         blk_open[i] = 1'b0;
         blk_prev[i] = 0;
         blk_next[i] = 0;
         blk_size[i] = 0;
      end
      blk_live[0]       = 1'b1;
      blk_open[0]       = 1'b1;
      blk_next[0]       = SENT_AT;
      blk_size[0]       = ARENA_BYTES - 2 * HEADER_BYTES;
      blk_live[SENT_AT] = 1'b1;
   endfunction

   // fold the free successor of lo into lo
   function automatic void merge_into(int lo);
      int nx = blk_next[lo];
      int nn;
      if (nx < SENT_AT) begin
         nn = blk_next[nx];
         if (nn < ARENA_BYTES) blk_prev[nn] = lo;
         blk_size[lo] = blk_size[lo] + blk_size[nx] + HEADER_BYTES;
         blk_next[lo] = nn;
         blk_live[nx] = 1'b0;
         blk_open[nx] = 1'b0;
      end
   endfunction

   function automatic rsp_type run_allocator(req_type it);
      rsp_type r   = '0;
      int      cur = 0;
      int      req = it.request_size;
      int      adr = it.block_address;
      int      h;
      int      nw;
      bit      hit = 1'b0;
      r.status = ST_OK;
      case (it.cmd)
         CMD_ALLOC: begin
            r.status = ST_OOM;
            for (int n = 0; n < ARENA_BYTES && cur < SENT_AT && !hit; n++) begin
               if (blk_open[cur] && blk_size[cur] >= req) begin
                  blk_open[cur] = 1'b0;
                  if (blk_size[cur] - req > HEADER_BYTES) begin
                     nw           = cur + HEADER_BYTES + req;
                     blk_live[nw] = 1'b1;
                     blk_open[nw] = 1'b1;
                     blk_prev[nw] = cur;
                     blk_next[nw] = blk_next[cur];
                     blk_size[nw] = blk_size[cur] - req - HEADER_BYTES;
                     if (blk_next[cur] < ARENA_BYTES) blk_prev[blk_next[cur]] = nw;
                     blk_next[cur] = nw;
                     blk_size[cur] = req;
                  end
                  r.payload_offset = ofs_type'(cur + HEADER_BYTES);
                  r.status         = ST_OK;
                  hit              = 1'b1;
               end else begin
                  cur = blk_next[cur];
               end
            end
         end
         CMD_FREE: begin
            if (adr < HEADER_BYTES || adr - HEADER_BYTES >= SENT_AT
                || !blk_live[adr - HEADER_BYTES]) begin
               r.status = ST_BAD;
            end else begin
               h           = adr - HEADER_BYTES;
               blk_open[h] = 1'b1;
               if (blk_next[h] < SENT_AT && blk_open[blk_next[h]]) merge_into(h);
               if (h != 0 && blk_prev[h] < ARENA_BYTES && blk_open[blk_prev[h]])
                  merge_into(blk_prev[h]);
            end
         end
         CMD_INIT: begin
            arena_format();
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // random request shaped by the current block chain
   function automatic req_type pick_request();
      req_type it;
      int      used_q [$];
      int      open_q [$];
      int      cur = 0;
      int      roll;
      int      s;
      it.request_size  = 15'($urandom);
      it.block_address = 9'($urandom);
      for (int n = 0; n < ARENA_BYTES && cur < SENT_AT; n++) begin
         if (blk_open[cur]) open_q.push_back(cur);
         else used_q.push_back(cur);
         cur = blk_next[cur];
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         it.cmd = CMD_INIT;
      end else if (roll < 5) begin
         it.cmd = CMD_SPARE;
      end else if (roll < 52 || (used_q.size() == 0 && roll < 85)) begin
         it.cmd = CMD_ALLOC;
         roll   = $urandom_range(0, 99);
         if (roll < 10) begin
            s = 0;
         end else if (roll < 55) begin
            s = $urandom_range(1, 24);
         end else if (roll < 70) begin
            s = $urandom_range(25, 120);
         end else if (roll < 82 && open_q.size() > 0) begin
            // exact fit, split threshold and just-too-big sizes
            s = blk_size[open_q[$urandom_range(0, open_q.size() - 1)]];
            case ($urandom_range(0, 4))
               0: s = s;
               1: s = s - HEADER_BYTES;
               2: s = s - HEADER_BYTES - 1;
               3: s = s + 1;
               default: s = s - 1;
            endcase
            if (s < 0) s = 0;
         end else if (roll < 95) begin
            s = $urandom_range(121, 520);
         end else begin
            s = $urandom_range(0, 32767);
         end
         it.request_size = 15'(s);
      end else begin
         it.cmd = CMD_FREE;
         roll   = $urandom_range(0, 99);
         if (roll < 75 && used_q.size() > 0)
            it.block_address = 9'(used_q[$urandom_range(0, used_q.size() - 1)] + HEADER_BYTES);
         else if (roll < 85 && open_q.size() > 0)
            it.block_address = 9'(open_q[$urandom_range(0, open_q.size() - 1)] + HEADER_BYTES);
         else
            it.block_address = 9'($urandom_range(0, 511));
      end
      return it;
   endfunction

   function automatic void add_row(logic [1:0] cmd, int size, int adr, bit typed, int off,
                                   logic [1:0] st);
      script_row row;
      row.item.cmd            = cmd;
      row.item.request_size   = 15'(size);
      row.item.block_address  = 9'(adr);
      row.typed               = typed;
      row.want.payload_offset = ofs_type'(off);
      row.want.status         = st;
      script.push_back(row);
   endfunction

   task automatic issue(req_type it, bit typed, rsp_type want);
      rsp_type got;
      start    <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      got = run_allocator(it);
      grant_q.push_back(typed ? want : got);
   endtask

   task automatic rest_between(bit last);
      if (last || $urandom_range(0, 99) < idle_pct) begin
         start    <= 1'b0;
         req_item <= {2'($urandom), 15'($urandom), 9'($urandom)};
         if (!last) repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   initial begin
      arena_format();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      add_row(CMD_ALLOC, 0,     511, 1, 7,   ST_OK);
      add_row(CMD_FREE,  32767, 7,   1, 0,   ST_OK);
      add_row(CMD_ALLOC, 32767, 0,   1, 0,   ST_OOM);
      add_row(CMD_ALLOC, 498,   0,   1, 7,   ST_OK);
      add_row(CMD_ALLOC, 0,     0,   1, 0,   ST_OOM);
      add_row(CMD_FREE,  0,     7,   1, 0,   ST_OK);
      add_row(CMD_FREE,  0,     0,   1, 0,   ST_BAD);
      add_row(CMD_FREE,  0,     6,   1, 0,   ST_BAD);
      add_row(CMD_FREE,  0,     511, 1, 0,   ST_BAD);
      add_row(CMD_FREE,  0,     8,   1, 0,   ST_BAD);
      add_row(CMD_ALLOC, 491,   0,   1, 7,   ST_OK);
      add_row(CMD_FREE,  0,     7,   1, 0,   ST_OK);
      add_row(CMD_ALLOC, 490,   0,   1, 7,   ST_OK);
      add_row(CMD_ALLOC, 1,     0,   1, 504, ST_OK);
      add_row(CMD_FREE,  0,     504, 1, 0,   ST_OK);
      add_row(CMD_FREE,  0,     504, 1, 0,   ST_OK);
      add_row(CMD_SPARE, 32767, 511, 1, 0,   ST_OK);
      add_row(CMD_INIT,  32767, 511, 1, 0,   ST_OK);
      add_row(CMD_ALLOC, 10,    0,   1, 7,   ST_OK);
      add_row(CMD_ALLOC, 20,    0,   1, 24,  ST_OK);
      add_row(CMD_ALLOC, 5,     0,   1, 51,  ST_OK);
      add_row(CMD_FREE,  0,     24,  0, 0,   ST_OK);
      add_row(CMD_FREE,  0,     7,   0, 0,   ST_OK);
      add_row(CMD_FREE,  0,     51,  0, 0,   ST_OK);
      add_row(CMD_ALLOC, 498,   0,   1, 7,   ST_OK);
      add_row(CMD_INIT,  0,     0,   1, 0,   ST_OK);

      foreach (script[i]) begin
         issue(script[i].item, script[i].typed, script[i].want);
         rest_between(1'b0);
      end

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k >= RANDOM_ITEMS - CALM_TAIL) begin
            idle_pct = 0;
         end else if (k % 50 == 0) begin
            case ($urandom_range(0, 2))
               0: idle_pct = 0;
               1: idle_pct = 25;
               default: idle_pct = 60;
            endcase
         end
         issue(pick_request(), 1'b0, '0);
         rest_between(k == RANDOM_ITEMS - 1);
      end

      while (grant_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (bad_count == 0)
         $display("tb_first_fit_arena_allocator_top OK");
      else
         $display("tb_first_fit_arena_allocator_top NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (grant_q.size() == 0) begin
            if (bad_count < 10)
               $display("unexpected reply: offset %0d status %0d",
                        rsp_item.payload_offset, rsp_item.status);
            bad_count++;
         end else begin
            want = grant_q.pop_front();
            if (rsp_item.payload_offset !== want.payload_offset
                || rsp_item.status !== want.status) begin
               if (bad_count < 10)
                  $display("reply mismatch: offset exp %0d got %0d, status exp %0d got %0d",
                           want.payload_offset, rsp_item.payload_offset,
                           want.status, rsp_item.status);
               bad_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_first_fit_arena_allocator_top NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

>>> files.f
src/ffaa_pkg.sv
src/ffaa_dp.sv
src/ffaa_ctrl.sv
src/first_fit_arena_allocator_top.sv
src/ffaa_checker.sv
bench/tb_first_fit_arena_allocator_top.sv
